// ===== src/csd_pkg.sv =====
package csd_pkg;

  // Width of the internal decoded-byte counter (8 to 32).
  localparam int LENGTH_BITS = 16;
  localparam int LEN_OUT_BITS = 16;
  localparam int LEN_EXT_BITS = 33;

  localparam logic [7:0] CODE_MAX = 8'd255;

  typedef logic [LENGTH_BITS-1:0] count_t;

  typedef enum logic [1:0] {
    PH_CODE  = 2'd0,
    PH_CHUNK = 2'd1,
    PH_AFTER = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_FRAME  = 2'd1,
    KIND_DESYNC = 2'd2
  } kind_t;

  function automatic count_t count_inc(input count_t c);
    return (c == '1) ? c : count_t'(c + count_t'(1));
  endfunction

  // Reported length saturates at the output field's maximum.
  function automatic logic [LEN_OUT_BITS-1:0] shown_len(input count_t c);
    logic [LEN_EXT_BITS-1:0] ext;
    ext = LEN_EXT_BITS'(c);
    return (ext > LEN_EXT_BITS'({LEN_OUT_BITS{1'b1}})) ? {LEN_OUT_BITS{1'b1}}
                                                         : ext[LEN_OUT_BITS-1:0];
  endfunction

endpackage

// ===== src/cobs_stream_decoder_unit.sv =====
// COBS stream decoder with a programmable delimiter byte. One encoded byte is
// taken per transaction and yields at most one result: a decoded data byte, a
// frame-complete marker carrying the decoded length, or a desync marker when a
// delimiter or a zero code shows up where it cannot be. A code byte that opens
// a chunk yields no result unless it releases a pending implied delimiter. The
// block sustains one byte per clock cycle: the decode updates a few state
// registers, the result lands in an output register in the next cycle, and a
// new byte is taken whenever that register is empty or being drained in the
// same cycle. Write the delimiter only while the block is idle.
module cobs_stream_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  out_byte,
  output logic [15:0] frame_length
);

  logic [7:0]              delimiter;
  csd_pkg::phase_t         phase, phase_next;
  logic [7:0]              bytes_remaining, bytes_remaining_next;
  logic                    no_implicit_delim, no_implicit_delim_next;
  csd_pkg::count_t         decoded_count, decoded_count_next;

  logic                    accept;
  logic                    res_valid;
  csd_pkg::kind_t          res_kind;
  logic [7:0]              res_byte;
  csd_pkg::count_t         count_up;
  logic [7:0]              rem_dec;
  logic [7:0]              code_rem;
  csd_pkg::kind_t          kind_q;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign count_up = csd_pkg::count_inc(decoded_count);
  assign rem_dec  = bytes_remaining - 8'd1;
  assign code_rem = in_byte - 8'd1;

  always_comb begin
    phase_next             = phase;
    bytes_remaining_next   = bytes_remaining;
    no_implicit_delim_next = no_implicit_delim;
    decoded_count_next     = decoded_count;
    res_valid              = 1'b0;
    res_kind               = csd_pkg::KIND_DATA;
    res_byte               = 8'd0;
    unique case (phase)
      csd_pkg::PH_CHUNK: begin
        res_valid = 1'b1;
        if (in_byte == delimiter) begin
          res_kind             = csd_pkg::KIND_DESYNC;
          decoded_count_next   = '0;
          phase_next           = csd_pkg::PH_CODE;
          bytes_remaining_next = 8'd0;
        end else begin
          res_byte             = in_byte;
          decoded_count_next   = count_up;
          bytes_remaining_next = rem_dec;
          if (rem_dec == 8'd0) begin
            phase_next = no_implicit_delim ? csd_pkg::PH_CODE : csd_pkg::PH_AFTER;
          end
        end
      end
      default: begin
        // code phase; a code byte here may first release the implied delimiter
        if (in_byte == delimiter || in_byte == 8'd0) begin
          res_valid            = 1'b1;
          res_kind             = (in_byte == delimiter) ? csd_pkg::KIND_FRAME
                                                        : csd_pkg::KIND_DESYNC;
          decoded_count_next   = '0;
          phase_next           = csd_pkg::PH_CODE;
          bytes_remaining_next = 8'd0;
        end else begin
          if (phase == csd_pkg::PH_AFTER) begin
            res_valid          = 1'b1;
            res_byte           = delimiter;
            decoded_count_next = count_up;
          end
          bytes_remaining_next   = code_rem;
          no_implicit_delim_next = (in_byte == csd_pkg::CODE_MAX);
          phase_next = (code_rem == 8'd0) ? csd_pkg::PH_AFTER : csd_pkg::PH_CHUNK;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter         <= 8'd0;
      phase             <= csd_pkg::PH_CODE;
      bytes_remaining   <= 8'd0;
      no_implicit_delim <= 1'b1;
      decoded_count     <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        delimiter <= cfg_data;
      end
      if (accept) begin
        phase             <= phase_next;
        bytes_remaining   <= bytes_remaining_next;
        no_implicit_delim <= no_implicit_delim_next;
        decoded_count     <= decoded_count_next;
        out_valid         <= res_valid;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Length is sampled after the update for data, before the clear otherwise.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q       <= res_kind;
      out_byte     <= res_byte;
      frame_length <= (res_kind == csd_pkg::KIND_DATA) ?
                      csd_pkg::shown_len(decoded_count_next) :
                      csd_pkg::shown_len(decoded_count);
    end
  end

  assign kind = kind_q;

  a_byte_zero_unless_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != csd_pkg::KIND_DATA) |-> out_byte == 8'd0)
    else $error("non-data result carries a byte");

  a_close_resets_state: assert property (@(posedge clk) disable iff (rst)
    (accept && res_valid && res_kind != csd_pkg::KIND_DATA) |=>
      (phase == csd_pkg::PH_CODE && decoded_count == '0 && bytes_remaining == 8'd0))
    else $error("frame close did not clear decoder state");

  a_chunk_has_bytes: assert property (@(posedge clk) disable iff (rst)
    phase == csd_pkg::PH_CHUNK |-> bytes_remaining != 8'd0)
    else $error("inside chunk with nothing left");

  a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(frame_length) && $stable(kind)))
    else $error("stalled result lost or changed");

  a_count_saturates: assert property (@(posedge clk) disable iff (rst)
    ($past(decoded_count) == '1 && $past(accept) && $past(res_kind) == csd_pkg::KIND_DATA
     && $past(res_valid)) |-> decoded_count == '1)
    else $error("length counter wrapped");

endmodule
